FILE: src/bsta_pkg.sv
`timescale 1ns / 1ps

package bsta_pkg;

  localparam int SLOTS    = 16;
  localparam int HANDLE_W = 4;
  localparam int ADDR_W   = 24;
  localparam int WIDE_W   = ADDR_W + 2;
  localparam int CNT_W    = 5;
  localparam int TOTAL_W  = 32;
  localparam int ALIGN_W  = 13;
  localparam int MODE_W   = 3;
  localparam int DIMS_W   = 4;
  localparam int STATUS_W = 3;

  localparam logic [ADDR_W-1:0] GRAIN_M1   = ADDR_W'(7);
  localparam logic [ADDR_W-1:0] POOL_RESET = ADDR_W'(65536);
  localparam logic [DIMS_W-1:0] DIMS_MAX   = DIMS_W'(4);

  // floor(x / 5) for x below 2**26 as (x * RECIP) >> RECIP_SHIFT
  localparam int               RECIP_W     = 27;
  localparam int               RECIP_SHIFT = 29;
  localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'((64'd1 << RECIP_SHIFT) / 5 + 1);
  localparam logic [WIDE_W-1:0]  POOL_X3_RESET = WIDE_W'(65536 * 3);

  localparam logic [MODE_W-1:0] MODE_TEMP_ALLOC    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FREE          = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PERSIST_ALLOC = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PERSIST_RESET = 3'd3;
  localparam logic [MODE_W-1:0] MODE_POOL_RESET    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_QUERY         = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOSPACE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOSLOT  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_INVALID = 3'd4;
  localparam logic [STATUS_W-1:0] ST_HOLE    = 3'd5;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [ADDR_W-1:0]   byte_count;
    logic [DIMS_W-1:0]   dims;
    logic [ALIGN_W-1:0]  align_bytes;
    logic [HANDLE_W-1:0] handle;
    logic [ADDR_W-1:0]   min_free;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] handle_out;
    logic [ADDR_W-1:0]   address;
    logic [ADDR_W-1:0]   size_out;
    logic                valid_res;
    logic [ADDR_W-1:0]   temp_used;
    logic [ADDR_W-1:0]   temp_free;
    logic [CNT_W-1:0]    active_tensors;
    logic [CNT_W-1:0]    peak_tensors;
    logic [TOTAL_W-1:0]  alloc_total;
    logic [ADDR_W-1:0]   persist_fill;
    logic                enough_free;
  } res_t;

endpackage

FILE: src/bsta_req_if.sv
`timescale 1ns / 1ps

interface bsta_req_if;
  import bsta_pkg::*;

  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [ADDR_W-1:0]   byte_count;
  logic [DIMS_W-1:0]   dims;
  logic [ALIGN_W-1:0]  align_bytes;
  logic [HANDLE_W-1:0] handle;
  logic [ADDR_W-1:0]   min_free;

  modport source (
    output valid, mode, byte_count, dims, align_bytes, handle, min_free,
    input  ready
  );

  modport sink (
    input  valid, mode, byte_count, dims, align_bytes, handle, min_free,
    output ready
  );
endinterface

FILE: src/bsta_res_if.sv
`timescale 1ns / 1ps

interface bsta_res_if;
  import bsta_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] handle_out;
  logic [ADDR_W-1:0]   address;
  logic [ADDR_W-1:0]   size_out;
  logic                valid_res;
  logic [ADDR_W-1:0]   temp_used;
  logic [ADDR_W-1:0]   temp_free;
  logic [CNT_W-1:0]    active_tensors;
  logic [CNT_W-1:0]    peak_tensors;
  logic [TOTAL_W-1:0]  alloc_total;
  logic [ADDR_W-1:0]   persist_fill;
  logic                enough_free;

  modport source (
    output valid, status, handle_out, address, size_out, valid_res, temp_used,
           temp_free, active_tensors, peak_tensors, alloc_total, persist_fill,
           enough_free,
    input  ready
  );

  modport sink (
    input  valid, status, handle_out, address, size_out, valid_res, temp_used,
           temp_free, active_tensors, peak_tensors, alloc_total, persist_fill,
           enough_free,
    output ready
  );
endinterface

FILE: src/bump_and_stack_tensor_allocator.sv
`timescale 1ns / 1ps

// tensor memory allocator: persistent bump region plus temporary stack region
// with a 16-entry handle table
// req channel: one request per transaction (temp alloc, free, persist alloc,
//   persist reset, pool reset, query); res channel: exactly one result per
//   request, in order, carrying status, handle, address and statistics
// cfg_we / cfg_wdata set the pool size; write only while no request is in
//   flight, and leave one idle cycle before the next request
// an accepted request is held in the request register and processed there; its
//   result moves into the result register once that register is empty or taken
// throughput: one request per cycle while results are taken; each request goes
//   through a single pass of logic between the request and result registers, the
//   free slot being picked by a priority encoder over the active bits
// reset: pool size 65536, all slots free, all counters and regions empty
// a stalled result holds res; one more request is buffered, then req.ready
//   drops until the result is taken
module bump_and_stack_tensor_allocator (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [bsta_pkg::ADDR_W-1:0] cfg_wdata,
  bsta_req_if.sink              req,
  bsta_res_if.source            res
);
  import bsta_pkg::*;

  // configuration and derived split
  logic [ADDR_W-1:0]           pool_len;
  logic [WIDE_W-1:0]           pool_x3;
  logic [WIDE_W+RECIP_W-1:0]   pool_prod;
  logic [ADDR_W-1:0]           persist_raw;
  logic [ADDR_W:0]             psize_sum;
  logic [ADDR_W-1:0]           psize;
  logic [ADDR_W-1:0]           tsize;

  // pipeline
  logic  s1_valid;
  req_t  s1;
  logic  out_valid;
  res_t  out;
  logic  advance;
  res_t  res_next;

  // allocator state
  logic [SLOTS-1:0]    slot_active;
  logic [ADDR_W-1:0]   slot_size   [SLOTS];
  logic [ADDR_W-1:0]   slot_offset [SLOTS];
  logic [ADDR_W-1:0]   stack_top;
  logic [ADDR_W-1:0]   bump_used;
  logic [CNT_W-1:0]    live_count;
  logic [CNT_W-1:0]    peak_count;
  logic [TOTAL_W-1:0]  success_count;

  logic [SLOTS-1:0]    slot_active_next;
  logic [ADDR_W-1:0]   stack_top_next;
  logic [ADDR_W-1:0]   bump_used_next;
  logic [CNT_W-1:0]    live_count_next;
  logic [CNT_W-1:0]    peak_count_next;
  logic [TOTAL_W-1:0]  success_count_next;
  logic                slot_wr;

  // free slot search
  logic                free_found;
  logic [HANDLE_W-1:0] free_idx;

  // temp alloc datapath
  logic [ADDR_W-1:0]   sz;
  logic [ADDR_W:0]     sz_sum;
  logic [ADDR_W:0]     sz_round;
  logic [WIDE_W-1:0]   ntop;
  logic                dims_bad;

  // free / query datapath
  logic [ADDR_W-1:0]   h_size;
  logic [ADDR_W-1:0]   h_off;
  logic [ADDR_W:0]     h_sum;
  logic [ADDR_W:0]     h_round;
  logic [WIDE_W-1:0]   h_end;
  logic [ADDR_W-1:0]   h_addr;

  // persist alloc datapath
  logic [ALIGN_W-1:0]  align_m1;
  logic [WIDE_W-1:0]   bump_sum;
  logic [WIDE_W-1:0]   p_off;
  logic [WIDE_W-1:0]   p_end;

  logic [ADDR_W-1:0]   tfree;

  assign pool_prod   = pool_x3 * RECIP;
  assign psize_sum   = {1'b0, persist_raw} + {1'b0, GRAIN_M1};
  assign psize       = {psize_sum[ADDR_W-1:3], 3'b000};
  assign tsize       = (psize > pool_len) ? '0 : pool_len - psize;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_len <= POOL_RESET;
      pool_x3  <= POOL_X3_RESET;
    end else if (cfg_we) begin
      pool_len <= cfg_wdata;
      pool_x3  <= {2'b00, cfg_wdata} + {1'b0, cfg_wdata, 1'b0};
    end
    persist_raw <= pool_prod[RECIP_SHIFT +: ADDR_W];
  end

  assign advance   = s1_valid && (!out_valid || res.ready);
  assign req.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1.mode        <= req.mode;
      s1.byte_count  <= req.byte_count;
      s1.dims        <= req.dims;
      s1.align_bytes <= req.align_bytes;
      s1.handle      <= req.handle;
      s1.min_free    <= req.min_free;
    end
    if (advance) begin
      out <= res_next;
    end
  end

  // lowest free slot wins
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!slot_active[i]) begin
        free_found = 1'b1;
        free_idx   = HANDLE_W'(i);
      end
    end
  end

  assign dims_bad = (s1.dims == '0) || (s1.dims > DIMS_MAX);
  assign sz       = (s1.byte_count == '0) ? ADDR_W'(1) : s1.byte_count;
  assign sz_sum   = {1'b0, sz} + {1'b0, GRAIN_M1};
  assign sz_round = {sz_sum[ADDR_W:3], 3'b000};
  assign ntop     = {2'b00, stack_top} + {1'b0, sz_round};

  assign h_size  = slot_size[s1.handle];
  assign h_off   = slot_offset[s1.handle];
  assign h_sum   = {1'b0, h_size} + {1'b0, GRAIN_M1};
  assign h_round = {h_sum[ADDR_W:3], 3'b000};
  assign h_end   = {2'b00, h_off} + {1'b0, h_round};
  assign h_addr  = psize + h_off;

  // alignment mask taken literally, also for non-powers of two
  assign align_m1 = (s1.align_bytes == '0) ? ALIGN_W'(7) : s1.align_bytes - ALIGN_W'(1);
  assign bump_sum = {2'b00, bump_used} + WIDE_W'(align_m1);
  assign p_off    = bump_sum & ~WIDE_W'(align_m1);
  assign p_end    = p_off + {2'b00, s1.byte_count};

  always_comb begin
    slot_active_next   = slot_active;
    stack_top_next     = stack_top;
    bump_used_next     = bump_used;
    live_count_next    = live_count;
    peak_count_next    = peak_count;
    success_count_next = success_count;
    slot_wr            = 1'b0;

    res_next            = '0;
    res_next.status     = ST_OK;

    unique case (s1.mode)
      MODE_TEMP_ALLOC: begin
        if (dims_bad) begin
          res_next.status = ST_BAD;
        end else if (ntop > {2'b00, tsize}) begin
          res_next.status = ST_NOSPACE;
        end else if (!free_found) begin
          res_next.status = ST_NOSLOT;
        end else begin
          slot_wr                    = 1'b1;
          slot_active_next[free_idx] = 1'b1;
          live_count_next            = live_count + CNT_W'(1);
          if (live_count_next > peak_count) begin
            peak_count_next = live_count_next;
          end
          res_next.handle_out = free_idx;
          res_next.address    = psize + stack_top;
          stack_top_next      = ntop[ADDR_W-1:0];
          success_count_next  = success_count + TOTAL_W'(1);
        end
      end
      MODE_FREE: begin
        res_next.handle_out = s1.handle;
        if (!slot_active[s1.handle]) begin
          res_next.status = ST_INVALID;
        end else begin
          res_next.address = h_addr;
          if (h_end == {2'b00, stack_top}) begin
            stack_top_next = h_off;
          end else begin
            res_next.status = ST_HOLE;
          end
          slot_active_next[s1.handle] = 1'b0;
          if (live_count != '0) begin
            live_count_next = live_count - CNT_W'(1);
          end
        end
      end
      MODE_PERSIST_ALLOC: begin
        if (p_end > {2'b00, psize}) begin
          res_next.status = ST_NOSPACE;
        end else begin
          res_next.address = p_off[ADDR_W-1:0];
          bump_used_next   = p_end[ADDR_W-1:0];
        end
      end
      MODE_PERSIST_RESET: begin
        bump_used_next = '0;
      end
      MODE_POOL_RESET: begin
        bump_used_next   = '0;
        stack_top_next   = '0;
        slot_active_next = '0;
        live_count_next  = '0;
      end
      MODE_QUERY: begin
        res_next.handle_out = s1.handle;
        if (slot_active[s1.handle]) begin
          res_next.valid_res = 1'b1;
          res_next.address   = h_addr;
          res_next.size_out  = h_size;
        end
      end
      default: begin
        res_next.status = ST_BAD;
      end
    endcase

    tfree = (tsize > stack_top_next) ? tsize - stack_top_next : '0;
    res_next.temp_used      = stack_top_next;
    res_next.temp_free      = tfree;
    res_next.active_tensors = live_count_next;
    res_next.peak_tensors   = peak_count_next;
    res_next.alloc_total    = success_count_next;
    res_next.persist_fill   = bump_used_next;
    res_next.enough_free    = (tfree >= s1.min_free);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_active   <= '0;
      stack_top     <= '0;
      bump_used     <= '0;
      live_count    <= '0;
      peak_count    <= '0;
      success_count <= '0;
    end else if (advance) begin
      slot_active   <= slot_active_next;
      stack_top     <= stack_top_next;
      bump_used     <= bump_used_next;
      live_count    <= live_count_next;
      peak_count    <= peak_count_next;
      success_count <= success_count_next;
    end
  end

  // size and offset tables are only read for active slots
  always_ff @(posedge clk) begin
    if (advance && slot_wr) begin
      slot_size[free_idx]   <= sz;
      slot_offset[free_idx] <= stack_top;
    end
  end

  assign res.valid          = out_valid;
  assign res.status         = out.status;
  assign res.handle_out     = out.handle_out;
  assign res.address        = out.address;
  assign res.size_out       = out.size_out;
  assign res.valid_res      = out.valid_res;
  assign res.temp_used      = out.temp_used;
  assign res.temp_free      = out.temp_free;
  assign res.active_tensors = out.active_tensors;
  assign res.peak_tensors   = out.peak_tensors;
  assign res.alloc_total    = out.alloc_total;
  assign res.persist_fill   = out.persist_fill;
  assign res.enough_free    = out.enough_free;

endmodule
